@@ src/ptes_pkg.sv @@
// Package of shared widths, codes and control structs for the periodic tick event scheduler.
`default_nettype none

package ptes_pkg;

    // Default configuration of the scheduler.
    localparam int DEF_SLOTS   = 10;
    localparam int DEF_TICK_MS = 10;

    // Fixed field widths of the item channels.
    localparam int PERIOD_W = 24;
    localparam int FIRE_W   = 10;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    // Result status codes carried on the output tuser bits.
    localparam logic [STATUS_W-1:0] ST_TICK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick;       // service all used slots and load a tick result
        logic reject;     // load a rejection result
        logic div_start;  // latch the period less one as the dividend
        logic div_step;   // form the reload by reciprocal multiplication
        logic commit;     // write the new slot and load an acceptance result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reg_ok;     // a registration offered now would be accepted
    } sts_t;

endpackage

`default_nettype wire

@@ src/ptes_ctrl.sv @@
// Controller state machine that sequences requests and owns the result valid flag.
`default_nettype none

module ptes_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          s_req_type,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire ptes_pkg::sts_t sts,
    output ptes_pkg::cmd_t     cmd
);
    import ptes_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DIV    = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       accept;
    logic       load_out;

    // The result register can take a new item when empty or being emptied.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign load_out = cmd.tick || cmd.reject || cmd.commit;

    // Next state and command decoding.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_TICK) begin
                        cmd.tick = 1'b1;
                    end else if (!sts.reg_ok) begin
                        cmd.reject = 1'b1;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result stays valid until the downstream side takes it.
    always_comb begin
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new result never overwrites one that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!out_valid_reg || m_tready))
        else $error("result loaded over an untaken item");

    // A loaded result is offered in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid)
        else $error("loaded result not presented");

    // No new item is taken while a registration is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV || state_reg == S_COMMIT) |-> !s_tready)
        else $error("item accepted during a registration");

endmodule

`default_nettype wire

@@ src/ptes_dp.sv @@
// Datapath with the slot table, the reload divider and the result register.
`default_nettype none

module ptes_dp #(
    parameter int SLOTS   = ptes_pkg::DEF_SLOTS,
    parameter int TICK_MS = ptes_pkg::DEF_TICK_MS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [ptes_pkg::PERIOD_W-1:0]     period_ms,
    input  wire ptes_pkg::cmd_t                    cmd,
    output ptes_pkg::sts_t                         sts,
    output logic [ptes_pkg::FIRE_W-1:0]            fire_mask,
    output logic [ptes_pkg::STATUS_W-1:0]          status,
    output logic [ptes_pkg::SLOT_W-1:0]            slot
);
    import ptes_pkg::*;

    localparam int UW = $clog2(SLOTS + 1);
    localparam int DW = $clog2(TICK_MS);
    localparam int SH = PERIOD_W + DW;
    localparam int MW = PERIOD_W + 2;
    localparam int PW = PERIOD_W + MW;
    localparam logic [UW-1:0] SlotsC = UW'(SLOTS);
    // Rounded-up reciprocal of the tick period; exact for every 24-bit dividend.
    localparam logic [63:0]   RecipL = ((64'd1 << SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam logic [MW-1:0] RecipC = MW'(RecipL);

    logic [UW-1:0]       used_reg;
    logic [PERIOD_W-1:0] reload_reg [SLOTS];
    logic [PERIOD_W-1:0] timer_reg  [SLOTS];

    logic [PERIOD_W-1:0] dvd_reg;
    logic [PERIOD_W-1:0] quot_reg;
    logic [PW-1:0]       prod;

    logic [SLOTS-1:0]    fire;
    logic [FIRE_W-1:0]   fire_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;

    // Registration is possible with a free slot and a nonzero period.
    assign sts.reg_ok = (used_reg < SlotsC) && (period_ms != '0);

    // The reload is (period - 1) / TICK_MS, formed by one reciprocal multiplication.
    assign prod = PW'(dvd_reg) * PW'(RecipC);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvd_reg <= period_ms - PERIOD_W'(1);
        end else if (cmd.div_step) begin
            quot_reg <= PERIOD_W'(prod >> SH);
        end
    end

    // Fire flags of the used slots whose timer has run out.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            fire[i] = (UW'(i) < used_reg) && (timer_reg[i] == '0);
        end
    end

    // Slot lanes: a tick counts down or reloads, a commit fills the next slot.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (cmd.commit && (UW'(i) == used_reg)) begin
                reload_reg[i] <= quot_reg;
                timer_reg[i]  <= quot_reg;
            end else if (cmd.tick && (UW'(i) < used_reg)) begin
                if (fire[i]) begin
                    timer_reg[i] <= reload_reg[i];
                end else begin
                    timer_reg[i] <= timer_reg[i] - PERIOD_W'(1);
                end
            end
        end
    end

    // Count of slots in use.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.commit) begin
            used_reg <= used_reg + UW'(1);
        end
    end

    // Result register; slots beyond the mask width fire without a visible bit.
    always_ff @(posedge aclk) begin
        if (cmd.tick) begin
            fire_reg   <= FIRE_W'(fire);
            status_reg <= ST_TICK;
            slot_reg   <= '0;
        end else if (cmd.reject) begin
            fire_reg   <= '0;
            status_reg <= ST_REJECT;
            slot_reg   <= '0;
        end else if (cmd.commit) begin
            fire_reg   <= '0;
            status_reg <= ST_ACCEPT;
            slot_reg   <= SLOT_W'(used_reg);
        end
    end

    assign fire_mask = fire_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;

    // The slot count never passes the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= SlotsC)
        else $error("slot count beyond table size");

    // A commit fills exactly one slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (used_reg == $past(used_reg) + UW'(1)))
        else $error("commit did not add one slot");

    // A commit only happens with a free slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (used_reg < SlotsC))
        else $error("commit into a full table");

endmodule

`default_nettype wire

@@ src/periodic_tick_event_scheduler.sv @@
// Top level of the periodic tick event scheduler: controller, datapath and stream ports.
// A tick or a rejected registration gives its result in the cycle after acceptance. An
// accepted registration gives its result once the dividend is latched, one reciprocal
// multiplication forms the reload, and the slot is written when the result register is free.
// Throughput: one tick item per cycle while the result register is empty or being emptied;
// after a registration no new item is taken until its slot is written. Reset: synchronous
// active-low aresetn empties the slot table and the result register.
`default_nettype none

module periodic_tick_event_scheduler #(
    parameter int SLOTS   = ptes_pkg::DEF_SLOTS,
    parameter int TICK_MS = ptes_pkg::DEF_TICK_MS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // period_ms[23:0]
    input  wire logic [ptes_pkg::S_DATA_W-1:0]     s_tdata,
    // req_type[0]
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // fire_mask[9:0], slot[13:10], zero[15:14]
    output logic [ptes_pkg::M_DATA_W-1:0]          m_tdata,
    // status[1:0]
    output logic [ptes_pkg::M_USER_W-1:0]          m_tuser
);
    import ptes_pkg::*;

    cmd_t                cmd;
    sts_t                sts;
    logic [FIRE_W-1:0]   fire_mask;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    ptes_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_req_type (s_tuser[0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    ptes_dp #(
        .SLOTS   (SLOTS),
        .TICK_MS (TICK_MS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .period_ms (s_tdata[PERIOD_W-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .fire_mask (fire_mask),
        .status    (status),
        .slot      (slot)
    );

    // Pack the result item onto the stream.
    assign m_tdata = {{(M_DATA_W - FIRE_W - SLOT_W){1'b0}}, slot, fire_mask};
    assign m_tuser = status;

endmodule

`default_nettype wire
